// ===== hw/rtl/ccr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccr_pkg : contrast ratio check, shared definitions
// Widths, luminance weights, pipeline control bundle and the sRGB
// linearisation function used to build the per-lane lookup tables.
// ----------------------------------------------------------------------------
package ccr_pkg;

	localparam int LIN_BITS   = 16;
	localparam int LIN_W      = LIN_BITS + 1;
	localparam int CODE_W     = 8;
	localparam int LUT_DEPTH  = 1 << CODE_W;
	localparam int THR_W      = 8;
	localparam int WT_BITS    = 16;
	localparam int PROD_W     = LIN_W + WT_BITS;
	localparam int SUM_W      = PROD_W + 2;
	localparam int TERM_W     = LIN_BITS + 5;
	localparam int FACT_W     = THR_W + 1;
	localparam int CMP_W      = LIN_BITS + 14;
	localparam int PIPE_DEPTH = 6;

	localparam logic [THR_W-1:0]   THR_RESET    = THR_W'(45);
	localparam logic [WT_BITS-1:0] WEIGHT_RED   = WT_BITS'(13933);
	localparam logic [WT_BITS-1:0] WEIGHT_GREEN = WT_BITS'(46871);
	localparam logic [WT_BITS-1:0] WEIGHT_BLUE  = WT_BITS'(4732);
	localparam logic [SUM_W-1:0]   SUM_ROUND    = SUM_W'(1) << (WT_BITS - 1);
	localparam logic [TERM_W-1:0]  TERM_ONE     = TERM_W'(1) << LIN_BITS;
	localparam logic [TERM_W-1:0]  TERM_SCALE   = TERM_W'(20);

	localparam longint unsigned LinSegLimit = 64'd1001640;
	localparam longint unsigned LinSegRound = 64'd16473;
	localparam longint unsigned LinSegDiv   = 64'd32946;
	localparam longint unsigned PowDiv      = 64'd269025;

	typedef struct packed {
		logic en;
		logic vld_s4;
	} pipe_ctrl_t;

	// sRGB code to linear light, unsigned Q1.LIN_BITS; elaboration only
	function automatic logic [LIN_W-1:0] lin_value(input int unsigned code);
		logic [63:0] c;
		logic [63:0] u;
		logic [63:0] a;
		logic [63:0] v;
		logic [63:0] y;
		logic [63:0] cand;
		logic [63:0] p;
		logic [63:0] res;
		c = 64'(code & 32'hFF);
		if (c * 64'd100000 <= LinSegLimit) begin
			res = (((c * 64'd10) << LIN_BITS) + LinSegRound) / LinSegDiv;
		end else if (c == 64'd255) begin
			res = 64'd1 << LIN_BITS;
		end else begin
			u = ((c * 64'd1000 + 64'd14025) << 32) / PowDiv;
			a = (u * u + (64'd1 << 31)) >> 32;
			v = 64'd0;
			for (int b = 31; b >= 0; b--) begin
				cand = v | (64'd1 << b);
				p = cand;
				for (int k = 0; k < 4; k++) begin
					p = (p * cand) >> 32;
				end
				if (p <= a) begin
					v = cand;
				end
			end
			y = (a * v) >> 32;
			res = (y + (64'd1 << (31 - LIN_BITS))) >> (32 - LIN_BITS);
		end
		return res[LIN_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/ccr_lane.sv =====
// ----------------------------------------------------------------------------
// ccr_lane : luminance lane
// Linearises the three channels of one colour through a constant table
// and forms the rounded weighted sum over three pipeline stages.
// ----------------------------------------------------------------------------
module ccr_lane
	import ccr_pkg::*;
(
	input  logic              clk,
	input  pipe_ctrl_t        ctrl,
	input  logic [CODE_W-1:0] red,
	input  logic [CODE_W-1:0] green,
	input  logic [CODE_W-1:0] blue,
	output logic [LIN_W-1:0]  luma_s3
);

	logic [LIN_W-1:0]  lin_rom [LUT_DEPTH];
	logic [LIN_W-1:0]  lin_r_s1, lin_g_s1, lin_b_s1;
	logic [PROD_W-1:0] prod_r_s2, prod_g_s2, prod_b_s2;
	logic [SUM_W-1:0]  sum;

	for (genvar i = 0; i < LUT_DEPTH; i++) begin : g_rom
		assign lin_rom[i] = lin_value(i);
	end

	assign sum = SUM_W'(prod_r_s2) + SUM_W'(prod_g_s2) + SUM_W'(prod_b_s2) + SUM_ROUND;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			lin_r_s1  <= lin_rom[red];
			lin_g_s1  <= lin_rom[green];
			lin_b_s1  <= lin_rom[blue];
			prod_r_s2 <= PROD_W'(lin_r_s1) * PROD_W'(WEIGHT_RED);
			prod_g_s2 <= PROD_W'(lin_g_s1) * PROD_W'(WEIGHT_GREEN);
			prod_b_s2 <= PROD_W'(lin_b_s1) * PROD_W'(WEIGHT_BLUE);
			luma_s3   <= LIN_W'(sum >> WT_BITS);
		end
	end

endmodule

// ===== hw/rtl/ccr_merge.sv =====
// ----------------------------------------------------------------------------
// ccr_merge : lane merge and threshold decision
// Orders the two luminances, scales the offset terms and compares
// 20*(20*Yhi+1) against (2T-1)*(20*Ylo+1) without division; a zero threshold always passes.
// ----------------------------------------------------------------------------
module ccr_merge
	import ccr_pkg::*;
(
	input  logic              clk,
	input  pipe_ctrl_t        ctrl,
	input  logic [LIN_W-1:0]  luma_a_s3,
	input  logic [LIN_W-1:0]  luma_b_s3,
	input  logic [THR_W-1:0]  thr,
	output logic              pass_s6
);

	logic [LIN_W-1:0]  hi, lo;
	logic [TERM_W-1:0] hi_term_s4, lo_term_s4;
	logic [FACT_W-1:0] fact_s4;
	logic              thr_zero_s4;
	logic [CMP_W-1:0]  lhs_s5, rhs_s5;
	logic              thr_zero_s5;

	always_comb begin
		if (luma_a_s3 > luma_b_s3) begin
			hi = luma_a_s3;
			lo = luma_b_s3;
		end else begin
			hi = luma_b_s3;
			lo = luma_a_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			hi_term_s4  <= TERM_W'(hi) * TERM_SCALE + TERM_ONE;
			lo_term_s4  <= TERM_W'(lo) * TERM_SCALE + TERM_ONE;
			fact_s4     <= {thr, 1'b0} - FACT_W'(1);
			thr_zero_s4 <= (thr == '0);
			lhs_s5      <= CMP_W'(hi_term_s4) * CMP_W'(TERM_SCALE);
			rhs_s5      <= CMP_W'(fact_s4) * CMP_W'(lo_term_s4);
			thr_zero_s5 <= thr_zero_s4;
			pass_s6     <= thr_zero_s5 || (lhs_s5 >= rhs_s5);
		end
	end

`ifndef ASSERT_OFF
	a_order: assert property (@(posedge clk) ctrl.vld_s4 |-> hi_term_s4 >= lo_term_s4)
		else $error("brighter term below darker term");
	a_term_floor: assert property (@(posedge clk) ctrl.vld_s4 |-> lo_term_s4 >= TERM_ONE)
		else $error("offset term lost its constant part");
	a_hi_cap: assert property (@(posedge clk)
		ctrl.vld_s4 |-> hi_term_s4 <= TERM_W'(21) * TERM_ONE)
		else $error("luminance term above white");
`endif

endmodule

// ===== hw/rtl/color_contrast_ratio_check.sv =====
// ----------------------------------------------------------------------------
// color_contrast_ratio_check : contrast ratio threshold test
// Throughput: one item per cycle; the six-stage pipeline stalls as a whole
// only while a result waits at the output.
// Reset: arst_n clears all stage valids and loads the threshold with 4.5:1.
// Two luminance lanes run in parallel, then the merge block decides.
// ----------------------------------------------------------------------------
module color_contrast_ratio_check
	import ccr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [THR_W-1:0]  cfg_wdata,
	input  logic              pair_valid,
	output logic              pair_ready,
	input  logic [CODE_W-1:0] red_a,
	input  logic [CODE_W-1:0] green_a,
	input  logic [CODE_W-1:0] blue_a,
	input  logic [CODE_W-1:0] red_b,
	input  logic [CODE_W-1:0] green_b,
	input  logic [CODE_W-1:0] blue_b,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              enough_contrast
);

	logic [PIPE_DEPTH-1:0] vld_q;
	logic [THR_W-1:0]      thr_q;
	logic [LIN_W-1:0]      luma_a_s3, luma_b_s3;
	logic                  en;
	pipe_ctrl_t            ctrl;

	assign en           = !vld_q[PIPE_DEPTH-1] || result_ready;
	assign pair_ready   = en;
	assign result_valid = vld_q[PIPE_DEPTH-1];
	assign ctrl.en      = en;
	assign ctrl.vld_s4  = vld_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			thr_q <= THR_RESET;
		end else begin
			if (en) begin
				vld_q <= {vld_q[PIPE_DEPTH-2:0], pair_valid};
			end
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
		end
	end

	ccr_lane u_lane_a (
		.clk     (clk),
		.ctrl    (ctrl),
		.red     (red_a),
		.green   (green_a),
		.blue    (blue_a),
		.luma_s3 (luma_a_s3)
	);

	ccr_lane u_lane_b (
		.clk     (clk),
		.ctrl    (ctrl),
		.red     (red_b),
		.green   (green_b),
		.blue    (blue_b),
		.luma_s3 (luma_b_s3)
	);

	ccr_merge u_merge (
		.clk       (clk),
		.ctrl      (ctrl),
		.luma_a_s3 (luma_a_s3),
		.luma_b_s3 (luma_b_s3),
		.thr       (thr_q),
		.pass_s6   (enough_contrast)
	);

`ifndef ASSERT_OFF
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && pair_ready |=> vld_q[0])
		else $error("accepted item missing from first stage");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_q[PIPE_DEPTH-2] |=> result_valid)
		else $error("item lost before output stage");
`endif

endmodule

// ===== tb/tb_color_contrast_ratio_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_color_contrast_ratio_check : contrast ratio threshold test bench
// Drives colour pairs into the block and checks every decision against a
// bit-exact predictor: own sRGB gamma lookup, luminance sum and the
// division-free rounded ratio test. Covers the reset threshold, threshold
// extremes (zero, above the 21:1 maximum) and a long random run with
// random idling on both sides.
// ----------------------------------------------------------------------------
module tb_color_contrast_ratio_check;
	import ccr_pkg::*;

	typedef struct packed {
		logic [CODE_W-1:0] r;
		logic [CODE_W-1:0] g;
		logic [CODE_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		rgb_t             ca;
		rgb_t             cb;
		logic [THR_W-1:0] thr;
		logic             pass;
	} verdict_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [THR_W-1:0]  cfg_wdata;
	logic              pair_valid;
	logic              pair_ready;
	logic [CODE_W-1:0] red_a;
	logic [CODE_W-1:0] green_a;
	logic [CODE_W-1:0] blue_a;
	logic [CODE_W-1:0] red_b;
	logic [CODE_W-1:0] green_b;
	logic [CODE_W-1:0] blue_b;
	logic              result_valid;
	logic              result_ready;
	logic              enough_contrast;

	logic [LIN_W-1:0]  gamma_lut [LUT_DEPTH];
	logic [THR_W-1:0]  thr_model;
	verdict_t          pending_verdicts [$];
	logic              no_idle;
	int unsigned       errors;
	int unsigned       pairs_sent;
	int unsigned       verdicts_checked;
	int unsigned       passes_seen;
	int unsigned       thr_writes;

	color_contrast_ratio_check i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.pair_valid      (pair_valid),
		.pair_ready      (pair_ready),
		.red_a           (red_a),
		.green_a         (green_a),
		.blue_a          (blue_a),
		.red_b           (red_b),
		.green_b         (green_b),
		.blue_b          (blue_b),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.enough_contrast (enough_contrast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("%0t: timeout, %0d items still outstanding", $time, pending_verdicts.size());
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------- predictor ----------------

	function automatic longint unsigned q32_fifth(longint unsigned x);
		longint unsigned acc;
		acc = x;
		repeat (4) acc = (acc * x) >> 32;
		return acc;
	endfunction

	function automatic logic [LIN_W-1:0] srgb_to_linear(int unsigned code);
		longint unsigned base;
		longint unsigned sq;
		longint unsigned root;
		longint unsigned trial;
		longint unsigned prod;
		if (code <= 10)
			return LIN_W'(((longint'(code) * 10 << LIN_BITS) + 16473) / 32946);
		if (code == 255)
			return LIN_W'(longint'(1) << LIN_BITS);
		base = ((longint'(code) * 1000 + 14025) << 32) / 269025;
		sq   = (base * base + (longint'(1) << 31)) >> 32;
		root = 0;
		for (int k = 31; k >= 0; k--) begin
			trial = root | (longint'(1) << k);
			if (q32_fifth(trial) <= sq)
				root = trial;
		end
		prod = (sq * root) >> 32;
		return LIN_W'((prod + (longint'(1) << (31 - LIN_BITS))) >> (32 - LIN_BITS));
	endfunction

	function automatic longint unsigned rel_luminance(rgb_t c);
		longint unsigned acc;
		acc = longint'(WEIGHT_RED) * gamma_lut[c.r]
			+ longint'(WEIGHT_GREEN) * gamma_lut[c.g]
			+ longint'(WEIGHT_BLUE) * gamma_lut[c.b];
		return (acc + 32768) >> 16;
	endfunction

	function automatic logic contrast_reaches(rgb_t ca, rgb_t cb, logic [THR_W-1:0] thr);
		longint unsigned la;
		longint unsigned lb;
		longint unsigned bright;
		longint unsigned dark;
		longint unsigned lhs;
		longint unsigned rhs;
		la     = rel_luminance(ca);
		lb     = rel_luminance(cb);
		bright = (la > lb) ? la : lb;
		dark   = (la > lb) ? lb : la;
		if (thr == '0)
			return 1'b1;
		lhs = 20 * (20 * bright + (longint'(1) << LIN_BITS));
		rhs = (2 * longint'(thr) - 1) * (20 * dark + (longint'(1) << LIN_BITS));
		return lhs >= rhs;
	endfunction

	// ---------------- drivers and checker ----------------

	always @(negedge clk) begin
		result_ready <= no_idle || ($urandom_range(99) >= 34);
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result, expected none, got enough_contrast=%0b",
					$time, enough_contrast);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_checked++;
				if (enough_contrast) passes_seen++;
				if (enough_contrast !== want.pass) begin
					$display("%0t: mismatch (%0d,%0d,%0d)/(%0d,%0d,%0d) T=%0d: expected %0b, got %0b",
						$time, want.ca.r, want.ca.g, want.ca.b, want.cb.r, want.cb.g, want.cb.b,
						want.thr, want.pass, enough_contrast);
					errors++;
				end
			end
		end
	end

	task automatic send_pair(rgb_t ca, rgb_t cb);
		verdict_t v;
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 34) begin
			pair_valid <= 1'b0;
			@(negedge clk);
		end
		pair_valid <= 1'b1;
		red_a      <= ca.r;
		green_a    <= ca.g;
		blue_a     <= ca.b;
		red_b      <= cb.r;
		green_b    <= cb.g;
		blue_b     <= cb.b;
		do @(posedge clk); while (!pair_ready);
		v.ca   = ca;
		v.cb   = cb;
		v.thr  = thr_model;
		v.pass = contrast_reaches(ca, cb, thr_model);
		pending_verdicts.push_back(v);
		pairs_sent++;
	endtask

	task automatic set_threshold(logic [THR_W-1:0] thr);
		@(negedge clk);
		pair_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (PIPE_DEPTH) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= thr;
		@(negedge clk);
		cfg_we    <= 1'b0;
		thr_model = thr;
		thr_writes++;
	endtask

	function automatic rgb_t random_rgb();
		rgb_t c;
		c.r = CODE_W'($urandom_range(255));
		if ($urandom_range(3) == 0) begin
			c.g = c.r;
			c.b = c.r;
		end else begin
			c.g = CODE_W'($urandom_range(255));
			c.b = CODE_W'($urandom_range(255));
		end
		return c;
	endfunction

	// ---------------- tests ----------------

	// reset threshold 4.5:1, extreme colours
	task automatic test_extremes();
		send_pair('{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255});
		send_pair('{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd0});
		send_pair('{8'd0, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0});
		send_pair('{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255});
		send_pair('{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd0, 8'd0});
		send_pair('{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd0});
		send_pair('{8'd0, 8'd0, 8'd255}, '{8'd0, 8'd0, 8'd0});
		send_pair('{8'd10, 8'd11, 8'd10}, '{8'd118, 8'd118, 8'd118});
	endtask

	// zero threshold, beyond 21:1, bounds and a near-boundary grey
	task automatic test_thresholds();
		logic [THR_W-1:0] thr_set [8];
		thr_set = '{8'd0, 8'd255, 8'd211, 8'd210, 8'd10, 8'd1, 8'd46, 8'd45};
		foreach (thr_set[i]) begin
			set_threshold(thr_set[i]);
			send_pair('{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255});
			send_pair('{8'd119, 8'd119, 8'd119}, '{8'd255, 8'd255, 8'd255});
		end
	endtask

	task automatic test_random();
		logic [THR_W-1:0] thr;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: thr = THR_RESET;
				1: thr = 8'd10;
				2: thr = 8'd210;
				4: thr = THR_W'($urandom_range(255));
				default: thr = THR_W'($urandom_range(10, 210));
			endcase
			set_threshold(thr);
			no_idle = (ph == 0);
			repeat (250) send_pair(random_rgb(), random_rgb());
			no_idle = 1'b0;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		pair_valid       = 1'b0;
		red_a            = '0;
		green_a          = '0;
		blue_a           = '0;
		red_b            = '0;
		green_b          = '0;
		blue_b           = '0;
		result_ready     = 1'b0;
		no_idle          = 1'b0;
		errors           = 0;
		pairs_sent       = 0;
		verdicts_checked = 0;
		passes_seen      = 0;
		thr_writes       = 0;
		thr_model        = THR_RESET;
		for (int i = 0; i < LUT_DEPTH; i++)
			gamma_lut[i] = srgb_to_linear(i);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_thresholds();
		test_random();

		@(negedge clk);
		pair_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (2 * PIPE_DEPTH) @(posedge clk);

		$display("Covered %0d colour pairs over %0d threshold settings; %0d results checked,",
			pairs_sent, thr_writes + 1, verdicts_checked);
		$display("%0d of them reaching the threshold, %0d errors.", passes_seen, errors);
		if (errors == 0 && pending_verdicts.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== color_contrast_ratio_check.f =====
hw/rtl/ccr_pkg.sv
hw/rtl/ccr_lane.sv
hw/rtl/ccr_merge.sv
hw/rtl/color_contrast_ratio_check.sv
tb/tb_color_contrast_ratio_check.sv
